/* rtl/core/pcp_pkg.sv */
// Package: payload, token and status types and character constants for the mode parser.
`timescale 1ns / 1ps

package pcp_pkg;

    // ASCII codes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;

    // ugo rwx masks
    localparam logic [8:0] MASK_ALL = 9'o777;
    localparam logic [8:0] WHO_U    = 9'o700;
    localparam logic [8:0] WHO_G    = 9'o070;
    localparam logic [8:0] WHO_O    = 9'o007;
    localparam logic [8:0] RIGHT_R  = 9'o444;
    localparam logic [8:0] RIGHT_W  = 9'o222;
    localparam logic [8:0] RIGHT_X  = 9'o111;

    localparam logic [3:0] LEN_MAX  = 4'd11;

    typedef enum logic [2:0] {
        ST_ABS    = 3'd0,
        ST_SYM    = 3'd1,
        ST_REJECT = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_LOAD   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_WHO    = 3'b001,
        PH_RIGHTS = 3'b010,
        PH_FAILED = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_SET = 2'd2
    } op_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       last;
        logic [8:0] load_value;
    } in_t;

    typedef struct packed {
        logic [8:0] mask_out;
        status_t    status;
        logic       end_of_command;
    } out_t;

    typedef struct packed {
        logic [3:0] len;
        logic [8:0] octal_value;
        logic       octal_ok;
        logic       leading_zero;
        logic [8:0] rwx_plain;
        logic       rwx_plain_ok;
        logic [8:0] rwx_off;
        logic       rwx_off_ok;
        phase_t     phase;
        logic [8:0] who;
        logic [8:0] rights;
        op_t        op;
    } tok_t;

    localparam tok_t TOK_CLEAR = '{
        len:          4'd0,
        octal_value:  9'd0,
        octal_ok:     1'b1,
        leading_zero: 1'b0,
        rwx_plain:    9'd0,
        rwx_plain_ok: 1'b1,
        rwx_off:      9'd0,
        rwx_off_ok:   1'b1,
        phase:        PH_WHO,
        who:          9'd0,
        rights:       9'd0,
        op:           OP_ADD
    };

    // events from the token tracker to the mask unit
    typedef struct packed {
        logic       load;
        logic       finish;
        logic       empty_end;
        logic       last;
        logic [8:0] load_value;
    } ev_t;

endpackage

/* rtl/core/permission_mode_command_parser.sv */
// Top level of the streaming chmod-style permission command parser.
//
// Usage: command characters arrive one per transfer on the s_ channel (cmd 0),
// with last marking the final character of a command string. Commas split
// tokens; each finished token gives one transfer on the m_ channel carrying
// the updated mask, a status and end_of_command. Empty tokens give nothing,
// except an empty final token, which reports status 3. A cmd 1 transfer loads
// load_value as the mask, drops any partial token and reports status 4.
// Each result is registered and on m_ in the cycle after its closing transfer.
// Throughput: one character per cycle unless stalled; token decode and mask
// update are a single pass of logic between the token and result registers.
// Stall: the result register holds a waiting result while m_ready is low, and
// s_ready follows it, so input is held off only while a result waits and the
// receiver is not taking it.
// Reset (aresetn low, synchronous): mask cleared to zero, open token
// cleared, result register emptied.
`timescale 1ns / 1ps

module permission_mode_command_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pcp_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pcp_pkg::out_t m_data
);

    logic          accept;
    logic          room;
    logic          res_valid;
    pcp_pkg::tok_t tok_done;
    pcp_pkg::ev_t  ev;
    pcp_pkg::out_t res;

    // every transfer may yield a result, so accept only with room for it
    assign s_ready = room;
    assign accept  = s_valid && s_ready;

    pcp_token u_token (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_data  (s_data),
        .tok_done (tok_done),
        .ev       (ev)
    );

    pcp_apply u_apply (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok       (tok_done),
        .ev        (ev),
        .res_valid (res_valid),
        .res       (res)
    );

    pcp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* rtl/core/pcp_token.sv */
// Token tracker: folds each character into the candidate decodes of the open token.
`timescale 1ns / 1ps

module pcp_token (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  pcp_pkg::in_t  in_data,
    output pcp_pkg::tok_t tok_done,
    output pcp_pkg::ev_t  ev
);

    pcp_pkg::tok_t tok_reg;
    pcp_pkg::tok_t tok_next;
    pcp_pkg::tok_t absorbed;
    logic          is_comma;
    logic          tok_end;

    // letter expected at slot i of a 9-char rwx field
    function automatic logic [7:0] slot_letter(input logic [3:0] i);
        logic [7:0] l;
        case (i) inside
            4'd0, 4'd3, 4'd6: l = pcp_pkg::CH_R;
            4'd1, 4'd4, 4'd7: l = pcp_pkg::CH_W;
            default:          l = pcp_pkg::CH_X;
        endcase
        return l;
    endfunction

    function automatic pcp_pkg::tok_t absorb(input pcp_pkg::tok_t t, input logic [7:0] c);
        pcp_pkg::tok_t n;
        logic [3:0]    p;
        logic [3:0]    s;
        n = t;
        p = t.len;
        s = p - 4'd1;

        if (p < 4'd4) begin
            if (c >= pcp_pkg::CH_ZERO && c <= pcp_pkg::CH_SEVEN) begin
                n.octal_value = {t.octal_value[5:0], c[2:0]};
            end else begin
                n.octal_ok = 1'b0;
            end
        end
        if (p == 4'd0) begin
            n.leading_zero = (c == pcp_pkg::CH_ZERO);
        end

        if (p < 4'd9) begin
            if (c == slot_letter(p)) begin
                n.rwx_plain[4'd8 - p] = 1'b1;
            end else if (c != pcp_pkg::CH_DASH) begin
                n.rwx_plain_ok = 1'b0;
            end
        end
        if (p >= 4'd1 && p <= 4'd9) begin
            if (c == slot_letter(s)) begin
                n.rwx_off[4'd8 - s] = 1'b1;
            end else if (c != pcp_pkg::CH_DASH) begin
                n.rwx_off_ok = 1'b0;
            end
        end

        unique case (t.phase)
            pcp_pkg::PH_WHO: begin
                if (c == pcp_pkg::CH_U) begin
                    n.who = t.who | pcp_pkg::WHO_U;
                end else if (c == pcp_pkg::CH_G) begin
                    n.who = t.who | pcp_pkg::WHO_G;
                end else if (c == pcp_pkg::CH_O) begin
                    n.who = t.who | pcp_pkg::WHO_O;
                end else if (c == pcp_pkg::CH_A) begin
                    n.who = pcp_pkg::MASK_ALL;
                end else if (c == pcp_pkg::CH_PLUS) begin
                    n.op    = pcp_pkg::OP_ADD;
                    n.phase = pcp_pkg::PH_RIGHTS;
                end else if (c == pcp_pkg::CH_DASH) begin
                    n.op    = pcp_pkg::OP_SUB;
                    n.phase = pcp_pkg::PH_RIGHTS;
                end else if (c == pcp_pkg::CH_EQ) begin
                    n.op    = pcp_pkg::OP_SET;
                    n.phase = pcp_pkg::PH_RIGHTS;
                end else begin
                    n.phase = pcp_pkg::PH_FAILED;
                end
            end
            pcp_pkg::PH_RIGHTS: begin
                if (c == pcp_pkg::CH_R) begin
                    n.rights = t.rights | pcp_pkg::RIGHT_R;
                end else if (c == pcp_pkg::CH_W) begin
                    n.rights = t.rights | pcp_pkg::RIGHT_W;
                end else if (c == pcp_pkg::CH_X) begin
                    n.rights = t.rights | pcp_pkg::RIGHT_X;
                end else begin
                    n.phase = pcp_pkg::PH_FAILED;
                end
            end
            default: n.phase = pcp_pkg::PH_FAILED;
        endcase

        if (p < pcp_pkg::LEN_MAX) begin
            n.len = p + 4'd1;
        end
        return n;
    endfunction

    assign is_comma = (in_data.ch == pcp_pkg::CH_COMMA);
    assign absorbed = is_comma ? tok_reg : absorb(tok_reg, in_data.ch);
    assign tok_end  = !in_data.cmd && (is_comma || in_data.last);
    assign tok_done = absorbed;

    assign ev.load       = accept && in_data.cmd;
    assign ev.finish     = accept && tok_end && (absorbed.len != 4'd0);
    assign ev.empty_end  = accept && !in_data.cmd && in_data.last && (absorbed.len == 4'd0);
    assign ev.last       = in_data.last;
    assign ev.load_value = in_data.load_value;

    always_comb begin
        tok_next = tok_reg;
        if (accept) begin
            if (in_data.cmd || tok_end) begin
                tok_next = pcp_pkg::TOK_CLEAR;
            end else begin
                tok_next = absorbed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= pcp_pkg::TOK_CLEAR;
        end else begin
            tok_reg <= tok_next;
        end
    end

endmodule

/* rtl/core/pcp_apply.sv */
// Mask unit: holds the permission mask, resolves finished tokens and forms results.
`timescale 1ns / 1ps

module pcp_apply (
    input  logic          aclk,
    input  logic          aresetn,
    input  pcp_pkg::tok_t tok,
    input  pcp_pkg::ev_t  ev,
    output logic          res_valid,
    output pcp_pkg::out_t res
);

    logic [8:0]       mask_reg;
    logic [8:0]       mask_next;
    logic [8:0]       fin_mask;
    pcp_pkg::status_t fin_status;
    logic [8:0]       who_eff;
    logic [8:0]       rights_eff;
    logic             octal_hit;

    assign octal_hit  = tok.octal_ok &&
                        ((tok.len == 4'd3) || ((tok.len == 4'd4) && tok.leading_zero));
    assign who_eff    = (tok.who == 9'd0) ? pcp_pkg::MASK_ALL : tok.who;
    assign rights_eff = tok.rights & who_eff;

    always_comb begin
        fin_mask   = mask_reg;
        fin_status = pcp_pkg::ST_REJECT;
        if (octal_hit) begin
            fin_mask   = tok.octal_value;
            fin_status = pcp_pkg::ST_ABS;
        end else if ((tok.len == 4'd9) && tok.rwx_plain_ok) begin
            fin_mask   = tok.rwx_plain;
            fin_status = pcp_pkg::ST_ABS;
        end else if ((tok.len == 4'd10) && tok.rwx_off_ok) begin
            fin_mask   = tok.rwx_off;
            fin_status = pcp_pkg::ST_ABS;
        end else if (tok.phase == pcp_pkg::PH_RIGHTS) begin
            fin_status = pcp_pkg::ST_SYM;
            case (tok.op)
                pcp_pkg::OP_ADD: fin_mask = mask_reg | rights_eff;
                pcp_pkg::OP_SUB: fin_mask = mask_reg & ~rights_eff;
                default:         fin_mask = (mask_reg & ~who_eff) | rights_eff;
            endcase
        end
    end

    always_comb begin
        mask_next = mask_reg;
        res       = '{mask_out: mask_reg, status: pcp_pkg::ST_EMPTY, end_of_command: 1'b1};
        if (ev.load) begin
            mask_next = ev.load_value;
            res       = '{mask_out: ev.load_value, status: pcp_pkg::ST_LOAD,
                          end_of_command: 1'b0};
        end else if (ev.finish) begin
            mask_next = fin_mask;
            res       = '{mask_out: fin_mask, status: fin_status, end_of_command: ev.last};
        end
    end

    assign res_valid = ev.load || ev.finish || ev.empty_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 9'd0;
        end else begin
            mask_reg <= mask_next;
        end
    end

endmodule

/* rtl/core/pcp_out_reg.sv */
// Result register: holds one result until the receiver takes it.
`timescale 1ns / 1ps

module pcp_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          res_valid,
    input  pcp_pkg::out_t res,
    output logic          room,
    output logic          m_valid,
    input  logic          m_ready,
    output pcp_pkg::out_t m_data
);

    logic          valid_reg;
    logic          valid_next;
    pcp_pkg::out_t data_reg;

    // free when empty or when the held result leaves this cycle
    assign room = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (room) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (room && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* rtl/core/pcp_checker.sv */
// Port checker for the mode parser and its bind to the top level.
`timescale 1ns / 1ps

module pcp_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input pcp_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input pcp_pkg::out_t m_data
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == pcp_pkg::ST_ABS || m_data.status == pcp_pkg::ST_SYM ||
                     m_data.status == pcp_pkg::ST_REJECT ||
                     m_data.status == pcp_pkg::ST_EMPTY || m_data.status == pcp_pkg::ST_LOAD))
        else $error("undefined status code");

    // a load transfer yields a load report carrying its value, never an end of command
    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd |=>
            m_valid && m_data.status == pcp_pkg::ST_LOAD &&
            m_data.mask_out == $past(s_data.load_value) && !m_data.end_of_command)
        else $error("load transfer not reported");

    // an empty final token always closes the command
    a_empty_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == pcp_pkg::ST_EMPTY |-> m_data.end_of_command)
        else $error("empty-token report without end of command");

endmodule

bind permission_mode_command_parser pcp_checker u_pcp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
